[hw/rtl/rhm_pkg.sv]
// ----------------------------------------------------------------------------
// rhm_pkg
// shared types and constants of the ring hopping matrix row generator
// ----------------------------------------------------------------------------
package rhm_pkg;

  localparam int OPCODE_W   = 2;
  localparam int INDEX_W    = 12;
  localparam int PATTERN_W  = 16;
  localparam int ENERGY_W   = 24;
  localparam int VALUE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int RING_W     = 5;
  localparam int COUNT_W    = 13;
  localparam int LEN_W      = 7;

  localparam logic [OPCODE_W-1:0] OP_LOAD_BASIS = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_SITE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_BUILD      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASIS_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_AMP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTERACTION = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_DIAG,
    ST_DEMIT,
    ST_HOP,
    ST_SADDR,
    ST_SCMP,
    ST_HEMIT
  } state_t;

  typedef struct packed {
    logic load_basis;
    logic load_site;
    logic start_row;
    logic latch_pattern;
    logic diag_step;
    logic emit_diag;
    logic srch_start;
    logic srch_read;
    logic srch_cmp;
    logic emit_hop;
    logic hop_skip;
  } cmd_t;

  typedef struct packed {
    logic row_ok;
    logic s_end;
    logic hop_here;
    logic rng_open;
    logic key_eq;
    logic out_free;
    logic no_hops;
    logic last_hop;
  } sts_t;

endpackage

[hw/rtl/rhm_if.sv]
// ----------------------------------------------------------------------------
// rhm_in_if / rhm_out_if
// request and result channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface rhm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] index;
  logic [15:0] pattern;
  logic signed [23:0] site_energy;

  modport source (output valid, opcode, index, pattern, site_energy, input ready);
  modport sink   (input valid, opcode, index, pattern, site_energy, output ready);
endinterface

interface rhm_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] row;
  logic [11:0] column;
  logic signed [31:0] value;
  logic        not_found;
  logic        last;

  modport source (output valid, row, column, value, not_found, last, input ready);
  modport sink   (input valid, row, column, value, not_found, last, output ready);
endinterface

[hw/rtl/rhm_ctrl.sv]
// ----------------------------------------------------------------------------
// rhm_ctrl
// sequencer: loads, diagonal sum, hop scan and bisection search
// ----------------------------------------------------------------------------
module rhm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [rhm_pkg::OPCODE_W-1:0] in_opcode,
  input  rhm_pkg::sts_t         sts,
  output rhm_pkg::cmd_t         cmd,
  output logic                  in_ready
);
  import rhm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_opcode)
            OP_LOAD_BASIS: cmd.load_basis = 1'b1;
            OP_LOAD_SITE:  cmd.load_site  = 1'b1;
            OP_BUILD: begin
              if (sts.row_ok) begin
                cmd.start_row = 1'b1;
                state_nxt     = ST_ROW;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ROW: begin
        cmd.latch_pattern = 1'b1;
        state_nxt         = ST_DIAG;
      end
      ST_DIAG: begin
        cmd.diag_step = 1'b1;
        if (sts.s_end) state_nxt = ST_DEMIT;
      end
      ST_DEMIT: begin
        if (sts.out_free) begin
          cmd.emit_diag = 1'b1;
          state_nxt     = sts.no_hops ? ST_IDLE : ST_HOP;
        end
      end
      ST_HOP: begin
        if (sts.hop_here) begin
          cmd.srch_start = 1'b1;
          state_nxt      = ST_SADDR;
        end else begin
          cmd.hop_skip = 1'b1;
        end
      end
      ST_SADDR: begin
        if (sts.rng_open) begin
          cmd.srch_read = 1'b1;
          state_nxt     = ST_SCMP;
        end else begin
          state_nxt = ST_HEMIT;
        end
      end
      ST_SCMP: begin
        cmd.srch_cmp = 1'b1;
        state_nxt    = sts.key_eq ? ST_HEMIT : ST_SADDR;
      end
      ST_HEMIT: begin
        if (sts.out_free) begin
          cmd.emit_hop = 1'b1;
          state_nxt    = sts.last_hop ? ST_IDLE : ST_HOP;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/rhm_datapath.sv]
// ----------------------------------------------------------------------------
// rhm_datapath
// tables, config registers, accumulator, search bounds and output register
// ----------------------------------------------------------------------------
module rhm_datapath #(
  parameter int SITES       = 16,
  parameter int BASIS_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rhm_pkg::cmd_t         cmd,
  output rhm_pkg::sts_t         sts,
  input  logic [rhm_pkg::INDEX_W-1:0]   in_index,
  input  logic [rhm_pkg::PATTERN_W-1:0] in_pattern,
  input  logic signed [rhm_pkg::ENERGY_W-1:0] in_site_energy,
  input  logic                  cfg_we,
  input  logic [rhm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rhm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [rhm_pkg::INDEX_W-1:0]   out_row,
  output logic [rhm_pkg::INDEX_W-1:0]   out_column,
  output logic signed [rhm_pkg::VALUE_W-1:0] out_value,
  output logic                  out_not_found,
  output logic                  out_last
);
  import rhm_pkg::*;

  localparam int SW = (SITES > 1) ? $clog2(SITES) : 1;
  localparam int AW = (BASIS_DEPTH > 1) ? $clog2(BASIS_DEPTH) : 1;
  localparam int CW = AW + 1;
  localparam int PW = (SITES > PATTERN_W) ? SITES : PATTERN_W;

  // config
  logic [RING_W-1:0]  ring_r;
  logic [COUNT_W-1:0] count_r;
  logic signed [ENERGY_W-1:0] hop_amp_r, inter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r    <= RING_W'(16);
      count_r   <= COUNT_W'(4096);
      hop_amp_r <= '0;
      inter_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RING_LENGTH: ring_r    <= cfg_data[RING_W-1:0];
        REG_BASIS_COUNT: count_r   <= cfg_data[COUNT_W-1:0];
        REG_HOP_AMP:     hop_amp_r <= cfg_data;
        REG_INTERACTION: inter_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective ring length and entry count
  logic [LEN_W-1:0] len;
  logic [CW-1:0]    cnt;
  always_comb begin
    len = LEN_W'(ring_r);
    if (len < LEN_W'(2)) len = LEN_W'(2);
    if (len > LEN_W'(SITES)) len = LEN_W'(SITES);
    if (32'(count_r) > 32'(BASIS_DEPTH)) cnt = CW'(BASIS_DEPTH);
    else cnt = CW'(count_r);
  end

  // tables
  logic [PATTERN_W-1:0] basis_mem [BASIS_DEPTH];
  logic [PATTERN_W-1:0] rdata_r;
  logic signed [ENERGY_W-1:0] energy_r [SITES];

  logic [CW-1:0] lo_r, hi_r, found_r, mid;
  logic          rd_en;
  logic [AW-1:0] raddr;

  assign mid   = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_en = cmd.start_row | cmd.srch_read;
  assign raddr = cmd.start_row ? AW'(in_index) : AW'(mid);

  always_ff @(posedge clk) begin
    if (cmd.load_basis && (32'(in_index) < 32'(BASIS_DEPTH)))
      basis_mem[AW'(in_index)] <= in_pattern;
    if (rd_en) rdata_r <= basis_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_site && (32'(in_index) < 32'(SITES)))
      energy_r[SW'(in_index)] <= in_site_energy;
  end

  // row state
  logic [INDEX_W-1:0] row_idx_r;
  logic [PW-1:0] p_r, hop_r, key_r;
  logic [SW-1:0] s_r, nx;
  logic signed [VALUE_W-1:0] acc_r;
  logic hit_r;

  logic [PW-1:0] mask, pw, hmask, s_bit, nx_bit, rd_ext;
  logic s_end;

  always_comb begin
    for (int i = 0; i < PW; i++) mask[i] = (LEN_W'(i) < len);
    pw = PW'(rdata_r) & mask;
    for (int i = 0; i < PW; i++)
      hmask[i] = mask[i] & (pw[i] ^ ((LEN_W'(i) + LEN_W'(1) == len) ? pw[0] : pw[(i+1)%PW]));
  end

  assign s_end  = (LEN_W'(s_r) + LEN_W'(1) == len);
  assign nx     = s_end ? '0 : SW'({1'b0, s_r} + 1'b1);
  assign s_bit  = PW'(1) << s_r;
  assign nx_bit = PW'(1) << nx;
  assign rd_ext = PW'(rdata_r);

  always_ff @(posedge clk) begin
    if (cmd.start_row) row_idx_r <= in_index;
    if (cmd.latch_pattern) begin
      p_r   <= pw;
      hop_r <= hmask;
      s_r   <= '0;
      acc_r <= '0;
    end
    if (cmd.diag_step) begin
      // at most 2*SITES terms of 24 bits: no overflow of 32 bits possible
      acc_r <= acc_r
             + (p_r[s_r] ? VALUE_W'(energy_r[s_r]) : '0)
             + ((p_r[s_r] & p_r[nx]) ? VALUE_W'(inter_r) : '0);
      s_r   <= nx;
    end
    if (cmd.hop_skip) s_r <= nx;
    if (cmd.emit_hop) begin
      s_r   <= nx;
      hop_r <= hop_r & ~s_bit;
    end
    if (cmd.srch_start) begin
      key_r   <= p_r ^ s_bit ^ nx_bit;
      lo_r    <= '0;
      hi_r    <= cnt;
      hit_r   <= 1'b0;
      found_r <= '0;
    end
    if (cmd.srch_cmp) begin
      if (rd_ext == key_r) begin
        hit_r   <= 1'b1;
        found_r <= mid;
      end else if (rd_ext < key_r) begin
        lo_r <= mid + 1'b1;
      end else begin
        hi_r <= mid;
      end
    end
  end

  // output register
  logic out_valid_r, out_nf_r, out_last_r;
  logic [INDEX_W-1:0] out_row_r, out_col_r;
  logic signed [VALUE_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_diag || cmd.emit_hop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_diag) begin
      out_row_r   <= row_idx_r;
      out_col_r   <= row_idx_r;
      out_value_r <= acc_r;
      out_nf_r    <= 1'b0;
      out_last_r  <= (hop_r == '0);
    end else if (cmd.emit_hop) begin
      out_row_r   <= hit_r ? INDEX_W'(found_r) : '0;
      out_col_r   <= row_idx_r;
      out_value_r <= VALUE_W'(hop_amp_r);
      out_nf_r    <= ~hit_r;
      out_last_r  <= ((hop_r & ~s_bit) == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_column    = out_col_r;
  assign out_value     = out_value_r;
  assign out_not_found = out_nf_r;
  assign out_last      = out_last_r;

  assign sts.row_ok   = (32'(in_index) < 32'(cnt));
  assign sts.s_end    = s_end;
  assign sts.hop_here = hop_r[s_r];
  assign sts.rng_open = (lo_r < hi_r);
  assign sts.key_eq   = (rd_ext == key_r);
  assign sts.out_free = ~out_valid_r | out_ready;
  assign sts.no_hops  = (hop_r == '0);
  assign sts.last_hop = ((hop_r & ~s_bit) == '0);

endmodule

[hw/rtl/ring_hopping_matrix_row_generator_core.sv]
// ----------------------------------------------------------------------------
// ring_hopping_matrix_row_generator_core
// builds one sparse matrix row per build request from the basis table
// ----------------------------------------------------------------------------
//
// channel   dir  handshake          payload
// in_ch     in   valid / ready      opcode, index, pattern, site_energy
// out_ch    out  valid / ready      row, column, value, not_found, last
// cfg_*     in   cfg_we only        cfg_index, cfg_data
//
// a load is taken in the idle state; a build fetches the row pattern, sums
// the diagonal site by site, then scans the sites for hops and per hop runs
// a bisection that alternates address and compare steps on the single read
// port of the basis memory
// one request in flight at a time; the next request is taken while the last
// result still sits in the output register
// a stalled output holds the sequencer only when a new entry is due
// synchronous active-low reset clears control state; tables stay undefined
//
module ring_hopping_matrix_row_generator_core #(
  parameter int SITES       = 16,
  parameter int BASIS_DEPTH = 4096
) (
  input  logic clk,
  input  logic rst_n,
  rhm_in_if.sink    in_ch,
  rhm_out_if.source out_ch,
  input  logic                              cfg_we,
  input  logic [rhm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rhm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rhm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  rhm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ch.ready)
  );

  // tables, search and output register
  rhm_datapath #(
    .SITES       (SITES),
    .BASIS_DEPTH (BASIS_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_index       (in_ch.index),
    .in_pattern     (in_ch.pattern),
    .in_site_energy (in_ch.site_energy),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_row        (out_ch.row),
    .out_column     (out_ch.column),
    .out_value      (out_ch.value),
    .out_not_found  (out_ch.not_found),
    .out_last       (out_ch.last)
  );

endmodule

[hw/rtl/rhm_checker.sv]
// ----------------------------------------------------------------------------
// rhm_checker
// port-level checks of the row generator, bound to the top level
// ----------------------------------------------------------------------------
module rhm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_opcode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_row,
  input logic [11:0] out_column,
  input logic [31:0] out_value,
  input logic        out_not_found,
  input logic        out_last
);
  import rhm_pkg::*;

  // a stalled result holds its row, column, value and last flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_column)
      && $stable(out_value) && $stable(out_last))
    else $error("result changed under stall");

  // a row in progress blocks new requests
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("request taken mid row");

  // a miss reports row zero
  a_miss_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_found |-> out_row == '0)
    else $error("miss with nonzero row");

  // after a load the request port is ready again in the next cycle
  a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == OP_LOAD_BASIS || in_opcode == OP_LOAD_SITE)
      |=> in_ready)
    else $error("load stalled the request port");

endmodule

bind ring_hopping_matrix_row_generator_core rhm_checker u_rhm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_opcode     (in_ch.opcode),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_row       (out_ch.row),
  .out_column    (out_ch.column),
  .out_value     (out_ch.value),
  .out_not_found (out_ch.not_found),
  .out_last      (out_ch.last)
);

[tb/rhm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rhm_scoreboard
// predicts the matrix entries of every build request and compares them with
// the entries leaving the row generator, in order
// ----------------------------------------------------------------------------
module rhm_scoreboard #(
  parameter int SITES       = 16,
  parameter int BASIS_DEPTH = 4096
) (
  input  logic clk,
  input  logic rst_n,
  rhm_in_if    in_ch,
  rhm_out_if   out_ch,
  input  logic                           cfg_we,
  input  logic [rhm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rhm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int   fail_count,
  output int   entries_pending
);
  import rhm_pkg::*;

  typedef struct {
    logic [11:0]        row;
    logic [11:0]        column;
    logic signed [31:0] value;
    logic               not_found;
    logic               last;
  } matrix_entry_t;

  logic [15:0]        basis_mem [BASIS_DEPTH];
  logic signed [23:0] onsite_mem [SITES];
  logic [4:0]         ring_len;
  logic [12:0]        basis_cnt;
  logic signed [23:0] hop_t;
  logic signed [23:0] inter_v;
  matrix_entry_t      expected_entries [$];

  // exact bisection over the first cnt entries
  function automatic bit find_pattern(logic [15:0] key, int cnt, output int found);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = cnt;
    found = 0;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (basis_mem[mid] == key) begin
        found = mid;
        return 1;
      end
      if (basis_mem[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return 0;
  endfunction

  task automatic predict_row(int idx);
    int            n;
    int            cnt;
    int            nx;
    int            f;
    bit            hit;
    logic [15:0]   p;
    logic [15:0]   q;
    longint        diag;
    matrix_entry_t e;
    matrix_entry_t row_q [$];
    n   = (ring_len < 2) ? 2 : ((ring_len > SITES) ? SITES : int'(ring_len));
    cnt = (basis_cnt > BASIS_DEPTH) ? BASIS_DEPTH : int'(basis_cnt);
    if (idx >= cnt) return;
    p = basis_mem[idx] & 16'((32'd1 << n) - 1);
    diag = 0;
    for (int s = 0; s < n; s++) begin
      nx = (s + 1 == n) ? 0 : s + 1;
      if (p[s]) begin
        diag += onsite_mem[s];
        if (p[nx]) diag += inter_v;
      end
    end
    if (diag > 64'sd2147483647) diag = 64'sd2147483647;
    if (diag < -64'sd2147483648) diag = -64'sd2147483648;
    e.row = 12'(idx);
    e.column = 12'(idx);
    e.value = 32'(diag);
    e.not_found = 0;
    e.last = 0;
    row_q = {row_q, e};
    for (int s = 0; s < n; s++) begin
      nx = (s + 1 == n) ? 0 : s + 1;
      if (p[s] != p[nx]) begin
        q = p ^ (16'd1 << s) ^ (16'd1 << nx);
        hit = find_pattern(q, cnt, f);
        e.row = hit ? 12'(f) : 12'd0;
        e.column = 12'(idx);
        e.value = 32'(hop_t);
        e.not_found = !hit;
        row_q = {row_q, e};
      end
    end
    row_q[row_q.size() - 1].last = 1;
    foreach (row_q[i]) expected_entries = {expected_entries, row_q[i]};
  endtask

  always @(posedge clk) begin
    matrix_entry_t exp_e;
    if (!rst_n) begin
      ring_len  <= 5'd16;
      basis_cnt <= 13'd4096;
      hop_t     <= '0;
      inter_v   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RING_LENGTH: ring_len  <= cfg_data[4:0];
          REG_BASIS_COUNT: basis_cnt <= cfg_data[12:0];
          REG_HOP_AMP:     hop_t     <= cfg_data;
          REG_INTERACTION: inter_v   <= cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.opcode)
          OP_LOAD_BASIS: basis_mem[in_ch.index] = in_ch.pattern;
          OP_LOAD_SITE:  if (in_ch.index < SITES) onsite_mem[in_ch.index] = in_ch.site_energy;
          OP_BUILD:      predict_row(in_ch.index);
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_entries.size() == 0) begin
          $error("unexpected entry row %0d column %0d", out_ch.row, out_ch.column);
          fail_count++;
        end else begin
          exp_e = expected_entries.pop_front();
          if (out_ch.row !== exp_e.row) begin
            $error("row mismatch: expected %0d actual %0d", exp_e.row, out_ch.row);
            fail_count++;
          end
          if (out_ch.column !== exp_e.column) begin
            $error("column mismatch: expected %0d actual %0d", exp_e.column, out_ch.column);
            fail_count++;
          end
          if (out_ch.value !== exp_e.value) begin
            $error("value mismatch: expected %0d actual %0d", exp_e.value, out_ch.value);
            fail_count++;
          end
          if (out_ch.not_found !== exp_e.not_found) begin
            $error("not_found mismatch: expected %0d actual %0d", exp_e.not_found,
                   out_ch.not_found);
            fail_count++;
          end
          if (out_ch.last !== exp_e.last) begin
            $error("last mismatch: expected %0d actual %0d", exp_e.last, out_ch.last);
            fail_count++;
          end
        end
      end
    end
    entries_pending <= expected_entries.size();
  end

  initial fail_count = 0;
endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the ring hopping matrix row generator: table loads,
// row builds over several register settings, random idling and back-pressure
// ----------------------------------------------------------------------------
module tb_top;
  import rhm_pkg::*;

  localparam int STALL_LIMIT = 20000;  // cycles with no request or entry moving
  localparam int SETTLE      = 300;    // cycles allowed after the last entry

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count;
  int entries_pending;

  // idling percentages, changed per phase
  int send_idle_pct;
  int recv_idle_pct;
  // long receiver hold-off request, counted in the receiver process
  bit hold_req;
  bit hold_seen;
  int hold_left;
  int stall_cycles;

  logic [15:0] sorted_pat [4096];

  rhm_in_if  in_ch ();
  rhm_out_if out_ch ();

  ring_hopping_matrix_row_generator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rhm_scoreboard u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .entries_pending (entries_pending)
  );

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver: random ready, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_seen) begin
      out_ch.ready <= 1'b0;
      hold_left <= 400;
      hold_seen <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one request on the input channel; values are sampled right after the edge
  task automatic send_request(logic [1:0] op, logic [11:0] idx, logic [15:0] pat,
                              logic [23:0] energy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.index       <= idx;
    in_ch.pattern     <= pat;
    in_ch.site_energy <= energy;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every expected entry has left, then let trailing work finish
  task automatic drain();
    stop_sending();
    while (entries_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] which, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick_energy();
    case ($urandom_range(0, 5))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic load_sites();
    for (int s = 0; s < 16; s++)
      send_request(OP_LOAD_SITE, 12'(s), 16'($urandom()), pick_energy());
    // site number beyond the table is dropped
    send_request(OP_LOAD_SITE, 12'($urandom_range(16, 4095)), 16'($urandom()),
                 pick_energy());
  endtask

  // fill slots 0..cnt-1; sorted tables are dense in the ring's pattern space
  task automatic load_basis(int cnt, int ring, bit sorted);
    int v;
    int span;
    int step_max;
    span = 1 << ((ring < 2) ? 2 : ((ring > 16) ? 16 : ring));
    step_max = (span / cnt < 1) ? 1 : span / cnt;
    v = $urandom_range(0, 2);
    for (int i = 0; i < cnt; i++) begin
      sorted_pat[i] = sorted ? 16'((v > 65535) ? 65535 : v) : 16'($urandom());
      v += $urandom_range(1, step_max);
    end
    for (int i = 0; i < cnt; i++)
      send_request(OP_LOAD_BASIS, 12'(i), sorted_pat[i], 24'($urandom()));
  endtask

  // builds with some noise mixed in: unused opcodes and rows beyond the filled slots
  task automatic random_builds(int filled, int n);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0:       send_request(2'd3, 12'($urandom()), 16'($urandom()), 24'($urandom()));
        1:       send_request(OP_BUILD, 12'($urandom_range(filled, 4095)),
                              16'($urandom()), 24'($urandom()));
        default: send_request(OP_BUILD, 12'($urandom_range(0, filled - 1)),
                              16'($urandom()), 24'($urandom()));
      endcase
    end
  endtask

  task automatic random_phase(int n_builds);
    int ring;
    int cnt;
    ring = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
    cnt  = $urandom_range(1, 6);
    drain();
    // upper data bits are junk the block must drop
    write_reg(REG_RING_LENGTH, {19'($urandom()), 5'(ring)});
    write_reg(REG_BASIS_COUNT, {11'($urandom()), 13'(cnt)});
    write_reg(REG_HOP_AMP, pick_energy());
    write_reg(REG_INTERACTION, pick_energy());
    load_basis(cnt, ring, $urandom_range(0, 4) != 0);
    if ($urandom_range(0, 2) == 0) load_sites();
    random_builds(cnt, n_builds);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOAD_BASIS;
    in_ch.index = '0;
    in_ch.pattern = '0;
    in_ch.site_energy = '0;
    hold_req = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 28;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 4-site ring, all two-particle patterns plus empty and full
    write_reg(REG_RING_LENGTH, 24'd4);
    write_reg(REG_BASIS_COUNT, 24'd8);
    write_reg(REG_HOP_AMP, 24'h7FFFFF);
    write_reg(REG_INTERACTION, 24'h800000);
    load_sites();
    sorted_pat = '{default: 16'h0};
    foreach (sorted_pat[i]) if (i < 8) sorted_pat[i] = 16'(0);
    send_request(OP_LOAD_BASIS, 12'd0, 16'h0000, 24'd0);
    send_request(OP_LOAD_BASIS, 12'd1, 16'h0003, 24'd0);
    send_request(OP_LOAD_BASIS, 12'd2, 16'h0005, 24'd0);
    send_request(OP_LOAD_BASIS, 12'd3, 16'h0006, 24'd0);
    send_request(OP_LOAD_BASIS, 12'd4, 16'h0009, 24'd0);
    send_request(OP_LOAD_BASIS, 12'd5, 16'h000A, 24'd0);
    send_request(OP_LOAD_BASIS, 12'd6, 16'h000C, 24'd0);
    send_request(OP_LOAD_BASIS, 12'd7, 16'hFFFF, 24'd0);
    for (int r = 0; r < 8; r++) send_request(OP_BUILD, 12'(r), 16'hFFFF, 24'hFFFFFF);
    send_request(OP_BUILD, 12'd8, 16'h0, 24'd0);       // beyond basis count: ignored
    send_request(2'd3, 12'hFFF, 16'hFFFF, 24'hFFFFFF); // unused opcode
    drain();

    // basis count zero: every build is dropped
    write_reg(REG_BASIS_COUNT, 24'd0);
    send_request(OP_BUILD, 12'd0, 16'h0, 24'd0);
    send_request(OP_BUILD, 12'hFFF, 16'h0, 24'd0);
    drain();

    // ring length below range, one entry table
    write_reg(REG_RING_LENGTH, 24'd1);
    write_reg(REG_BASIS_COUNT, 24'd1);
    send_request(OP_LOAD_BASIS, 12'd0, 16'hAAAA, 24'd0);
    send_request(OP_BUILD, 12'd0, 16'h0, 24'd0);
    drain();

    // random phases, one with no idling at all
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 28;
        recv_idle_pct = 28;
      end
      random_phase(5);
    end

    // back-pressure: receiver holds off while builds keep coming
    random_phase(2);
    hold_req <= 1'b1;
    random_builds(1, 8);
    // sender pauses until everything is out, then goes on
    stop_sending();
    while (entries_pending != 0) @(posedge clk);
    random_builds(1, 4);

    // count above depth, ring length above range; rows that need no search
    drain();
    write_reg(REG_RING_LENGTH, 24'd31);
    write_reg(REG_BASIS_COUNT, 24'd8191);
    write_reg(REG_HOP_AMP, 24'h800000);
    write_reg(REG_INTERACTION, 24'h7FFFFF);
    send_request(OP_LOAD_BASIS, 12'd0, 16'h0000, 24'd0);
    send_request(OP_LOAD_BASIS, 12'd4095, 16'hFFFF, 24'd0);
    send_request(OP_BUILD, 12'd4095, 16'h0, 24'd0);
    send_request(OP_BUILD, 12'd0, 16'h0, 24'd0);

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/rhm_pkg.sv
hw/rtl/rhm_if.sv
hw/rtl/rhm_ctrl.sv
hw/rtl/rhm_datapath.sv
hw/rtl/ring_hopping_matrix_row_generator_core.sv
hw/rtl/rhm_checker.sv
tb/rhm_checker.sv
tb/tb_top.sv
